// ===== hw/rtl/page_run_allocator_assert.svh =====
// Assertion helpers for the page run allocator.
`ifndef PAGE_RUN_ALLOCATOR_ASSERT_SVH
`define PAGE_RUN_ALLOCATOR_ASSERT_SVH

// Checks a property on every rising clock edge outside reset.
`define PRA_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Checks an implication that is sampled on the same edge.
`define PRA_IMPLY(lbl, ante, cons, msg) \
    `PRA_CHECK(lbl, (ante) |-> (cons), msg)

`endif

// ===== hw/rtl/pra_pkg.sv =====
// ----------------------------------------------------------------------------
// pra_pkg
// Shared constants for the page run allocator: status codes, op codes, field
// widths and parameter defaults.
// ----------------------------------------------------------------------------
`default_nettype none

package pra_pkg;
    localparam int REGION_PAGES_DEF  = 1024;
    localparam int TABLE_ENTRIES_DEF = 64;

    localparam int REQ_W   = 11;
    localparam int PAGE_W  = 20;
    localparam int BRK_W   = 11;
    localparam int STAT_W  = 3;
    localparam int BASE_W  = 20;
    localparam int USABLE_W = 11;

    localparam logic [STAT_W-1:0] ST_OK         = 3'd0;
    localparam logic [STAT_W-1:0] ST_NO_SPACE   = 3'd1;
    localparam logic [STAT_W-1:0] ST_UNRECORDED = 3'd2;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND  = 3'd3;
    localparam logic [STAT_W-1:0] ST_ZERO       = 3'd4;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;
endpackage

`default_nettype wire

// ===== hw/rtl/page_run_allocator.sv =====
// ----------------------------------------------------------------------------
// page_run_allocator
// Page-granular allocator: exact-fit, then largest-fit, then break extension.
// Page ownership is kept in a one-bit coverage memory, allocations in an
// entry memory with valid flags in flip-flops.
// ----------------------------------------------------------------------------
//  Channel   Direction  Beat contents
//  s_axis    in         tuser: op; tdata: req_pages[10:0], free_page[30:11]
//  m_axis    out        tuser: status; tdata: grant_page[19:0], break_now[30:20]
//  APB       in         0x0 base_page, 0x4 usable_pages
//
//  One request at a time. An allocate scans the coverage memory read port up to
//  the break, searches the entry table for a free slot, and marks req_pages
//  pages. A free searches every entry, unmarks the run's length in pages, and
//  lowers the break page by page while the page below it is free. After reset
//  a clearing pass runs over the whole coverage memory before the first request
//  is taken; configuration writes are taken throughout. A result waits in the
//  output register until taken, and no new request is accepted meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module page_run_allocator #(
    parameter int REGION_PAGES  = pra_pkg::REGION_PAGES_DEF,
    parameter int TABLE_ENTRIES = pra_pkg::TABLE_ENTRIES_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // req_pages[10:0], free_page[30:11], zero pad
    input  wire logic [31:0]                i_s_axis_tdata,
    // op
    input  wire logic                       i_s_axis_tuser,
    output logic                            o_m_axis_tvalid,
    input  wire logic                       i_m_axis_tready,
    // grant_page[19:0], break_now[30:20], zero pad
    output logic [31:0]                     o_m_axis_tdata,
    // status
    output logic [pra_pkg::STAT_W-1:0]      o_m_axis_tuser,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [2:0]                 paddr,
    input  wire logic [31:0]                pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import pra_pkg::*;

    localparam int AW   = $clog2(REGION_PAGES);
    localparam int CW   = $clog2(REGION_PAGES + 1);
    localparam int IW   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int LW   = (CW > REQ_W) ? CW : REQ_W;
    localparam int SUMW = LW + 1;

    localparam logic [3:0] S_CLR     = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_SCAN    = 4'd2;
    localparam logic [3:0] S_DECIDE  = 4'd3;
    localparam logic [3:0] S_SLOT    = 4'd4;
    localparam logic [3:0] S_MARK    = 4'd5;
    localparam logic [3:0] S_FSRCH   = 4'd6;
    localparam logic [3:0] S_FEND    = 4'd7;
    localparam logic [3:0] S_UNMARK  = 4'd8;
    localparam logic [3:0] S_LOW_RD  = 4'd9;
    localparam logic [3:0] S_LOW_CK  = 4'd10;
    localparam logic [3:0] S_DONE    = 4'd11;

    // Configuration registers.
    logic [BASE_W-1:0]   r_base;
    logic [USABLE_W-1:0] r_usable;

    // Control state.
    logic [3:0]          r_state;
    logic [CW-1:0]       r_break;
    logic                r_valid [TABLE_ENTRIES];
    logic                r_out_v;
    logic [STAT_W-1:0]   r_out_stat;
    logic [PAGE_W-1:0]   r_out_grant;
    logic [BRK_W-1:0]    r_out_brk;

    // Working registers for one request.
    logic [REQ_W-1:0]    r_req;
    logic [CW-1:0]       r_p;
    logic                r_ev_v;
    logic [CW-1:0]       r_ev_p;
    logic [IW-1:0]       r_ev_idx;
    logic [CW-1:0]       r_run_len;
    logic [AW-1:0]       r_run_at;
    logic                r_have_exact;
    logic [AW-1:0]       r_exact_at;
    logic                r_have_worst;
    logic [CW-1:0]       r_worst_len;
    logic [AW-1:0]       r_worst_at;
    logic [AW-1:0]       r_at;
    logic [IW:0]         r_idx;
    logic [CW-1:0]       r_k;
    logic                r_found;
    logic [CW-1:0]       r_flen;
    logic [STAT_W-1:0]   r_stat;
    logic [PAGE_W-1:0]   r_grant;

    // Memories.
    logic                r_cov_mem [REGION_PAGES];
    logic                r_cov_rd;
    logic [AW-1:0]       r_ent_start_mem [TABLE_ENTRIES];
    logic [CW-1:0]       r_ent_len_mem [TABLE_ENTRIES];
    logic [AW-1:0]       r_ent_start_rd;
    logic [CW-1:0]       r_ent_len_rd;

    logic                cov_we;
    logic [AW-1:0]       cov_waddr;
    logic                cov_wdata;
    logic [AW-1:0]       cov_raddr;
    logic                ent_we;

    logic [LW-1:0]       lim;
    logic                in_fire;
    logic                out_fire;
    logic [REQ_W-1:0]    in_req;
    logic [PAGE_W-1:0]   in_page;
    logic [PAGE_W-1:0]   in_rel;
    logic                busy;
    logic                ent_match;
    logic [CW-1:0]       mark_page;

    assign lim = (LW'(r_usable) > LW'(REGION_PAGES)) ? LW'(REGION_PAGES) : LW'(r_usable);

    assign in_fire  = i_s_axis_tvalid && o_s_axis_tready;
    assign out_fire = o_m_axis_tvalid && i_m_axis_tready;
    assign in_req   = i_s_axis_tdata[REQ_W-1:0];
    assign in_page  = i_s_axis_tdata[REQ_W+PAGE_W-1:REQ_W];
    assign in_rel   = in_page - r_base;

    assign o_s_axis_tready = (r_state == S_IDLE) && !r_out_v;
    assign o_m_axis_tvalid = r_out_v;
    assign o_m_axis_tuser  = r_out_stat;
    assign o_m_axis_tdata  = {1'b0, r_out_brk, r_out_grant};

    assign pready = 1'b1;
    assign prdata = paddr[2] ? {{(32-USABLE_W){1'b0}}, r_usable}
                             : {{(32-BASE_W){1'b0}}, r_base};

    // The page at the break closes the last run, as if it were taken.
    assign busy      = (r_ev_p == r_break) || r_cov_rd;
    assign ent_match = r_valid[r_ev_idx] && (r_ent_start_rd == r_at);
    assign mark_page = CW'(r_at) + r_k;

    always_comb begin
        cov_we    = 1'b0;
        cov_waddr = AW'(mark_page);
        cov_wdata = 1'b0;
        cov_raddr = AW'(r_p);
        ent_we    = 1'b0;
        case (r_state)
            S_CLR: begin
                cov_we    = 1'b1;
                cov_waddr = AW'(r_k);
            end
            S_MARK: begin
                cov_we    = 1'b1;
                cov_wdata = 1'b1;
            end
            S_UNMARK: begin
                cov_we = 1'b1;
            end
            S_LOW_RD: begin
                cov_raddr = AW'(r_break - CW'(1));
            end
            S_SLOT: begin
                ent_we = !r_valid[r_idx[IW-1:0]];
            end
            default: begin
                cov_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (cov_we) begin
            r_cov_mem[cov_waddr] <= cov_wdata;
        end
        r_cov_rd <= r_cov_mem[cov_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (ent_we) begin
            r_ent_start_mem[r_idx[IW-1:0]] <= r_at;
            r_ent_len_mem[r_idx[IW-1:0]]   <= CW'(r_req);
        end
        r_ent_start_rd <= r_ent_start_mem[r_idx[IW-1:0]];
        r_ent_len_rd   <= r_ent_len_mem[r_idx[IW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base   <= '0;
            r_usable <= USABLE_W'(1024);
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[2]) begin
                r_usable <= pwdata[USABLE_W-1:0];
            end else begin
                r_base <= pwdata[BASE_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_break <= '0;
            r_out_v <= 1'b0;
            r_k     <= '0;
            r_ev_v  <= 1'b0;
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                r_valid[i] <= 1'b0;
            end
        end else begin
            if (out_fire) begin
                r_out_v <= 1'b0;
            end
            case (r_state)
                S_CLR: begin
                    r_k <= r_k + CW'(1);
                    if (r_k == CW'(REGION_PAGES - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_fire) begin
                        r_req   <= in_req;
                        r_grant <= '0;
                        r_p     <= '0;
                        r_idx   <= '0;
                        r_k     <= '0;
                        r_ev_v  <= 1'b0;
                        r_found <= 1'b0;
                        r_run_len    <= '0;
                        r_have_exact <= 1'b0;
                        r_have_worst <= 1'b0;
                        r_worst_len  <= '0;
                        if (i_s_axis_tuser == OP_ALLOC) begin
                            if (in_req == '0) begin
                                r_stat  <= ST_ZERO;
                                r_state <= S_DONE;
                            end else begin
                                r_state <= S_SCAN;
                            end
                        end else if (in_rel >= PAGE_W'(lim)) begin
                            r_stat  <= ST_NOT_FOUND;
                            r_state <= S_DONE;
                        end else begin
                            r_at    <= AW'(in_rel);
                            r_state <= S_FSRCH;
                        end
                    end
                end
                S_SCAN: begin
                    // Reads run one page ahead of the run tracking.
                    if (r_p <= r_break) begin
                        r_ev_v <= 1'b1;
                        r_ev_p <= r_p;
                        r_p    <= r_p + CW'(1);
                    end else begin
                        r_ev_v <= 1'b0;
                    end
                    if (r_ev_v) begin
                        if (!busy) begin
                            if (r_run_len == '0) begin
                                r_run_at <= AW'(r_ev_p);
                            end
                            r_run_len <= r_run_len + CW'(1);
                        end else begin
                            if (LW'(r_run_len) >= LW'(r_req)) begin
                                if ((LW'(r_run_len) == LW'(r_req)) && !r_have_exact) begin
                                    r_have_exact <= 1'b1;
                                    r_exact_at   <= r_run_at;
                                end
                                if (r_run_len > r_worst_len) begin
                                    r_have_worst <= 1'b1;
                                    r_worst_len  <= r_run_len;
                                    r_worst_at   <= r_run_at;
                                end
                            end
                            r_run_len <= '0;
                        end
                        if (r_ev_p == r_break) begin
                            r_state <= S_DECIDE;
                        end
                    end
                end
                S_DECIDE: begin
                    r_idx <= '0;
                    if (r_have_exact) begin
                        r_at    <= r_exact_at;
                        r_grant <= r_base + PAGE_W'(r_exact_at);
                        r_state <= S_SLOT;
                    end else if (r_have_worst) begin
                        r_at    <= r_worst_at;
                        r_grant <= r_base + PAGE_W'(r_worst_at);
                        r_state <= S_SLOT;
                    end else if (SUMW'(r_break) + SUMW'(r_req) < SUMW'(lim)) begin
                        r_at    <= AW'(r_break);
                        r_grant <= r_base + PAGE_W'(r_break);
                        r_break <= CW'(SUMW'(r_break) + SUMW'(r_req));
                        r_state <= S_SLOT;
                    end else begin
                        r_stat  <= ST_NO_SPACE;
                        r_state <= S_DONE;
                    end
                end
                S_SLOT: begin
                    if (!r_valid[r_idx[IW-1:0]]) begin
                        r_valid[r_idx[IW-1:0]] <= 1'b1;
                        r_stat  <= ST_OK;
                        r_k     <= '0;
                        r_state <= S_MARK;
                    end else if (r_idx == (IW+1)'(TABLE_ENTRIES - 1)) begin
                        // Table full: the grant stands but is neither recorded nor marked.
                        r_stat  <= ST_UNRECORDED;
                        r_state <= S_DONE;
                    end else begin
                        r_idx <= r_idx + (IW+1)'(1);
                    end
                end
                S_MARK: begin
                    r_k <= r_k + CW'(1);
                    if (r_k == CW'(r_req) - CW'(1)) begin
                        r_state <= S_DONE;
                    end
                end
                S_FSRCH: begin
                    if (r_idx < (IW+1)'(TABLE_ENTRIES)) begin
                        r_ev_v   <= 1'b1;
                        r_ev_idx <= r_idx[IW-1:0];
                        r_idx    <= r_idx + (IW+1)'(1);
                    end else begin
                        r_ev_v <= 1'b0;
                    end
                    // Later indices override, so the highest match wins.
                    if (r_ev_v) begin
                        if (ent_match) begin
                            r_found <= 1'b1;
                            r_flen  <= r_ent_len_rd;
                            r_k     <= CW'(r_ev_idx);
                        end
                        if (r_ev_idx == IW'(TABLE_ENTRIES - 1)) begin
                            r_state <= S_FEND;
                        end
                    end
                end
                S_FEND: begin
                    r_k <= '0;
                    if (r_found) begin
                        r_valid[IW'(r_k)] <= 1'b0;
                        r_stat  <= ST_OK;
                        r_state <= S_UNMARK;
                    end else begin
                        r_stat  <= ST_NOT_FOUND;
                        r_state <= S_DONE;
                    end
                end
                S_UNMARK: begin
                    r_k <= r_k + CW'(1);
                    if (r_k == r_flen - CW'(1)) begin
                        r_state <= S_LOW_RD;
                    end
                end
                S_LOW_RD: begin
                    if (r_break == '0) begin
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_LOW_CK;
                    end
                end
                S_LOW_CK: begin
                    if (!r_cov_rd) begin
                        r_break <= r_break - CW'(1);
                        r_state <= S_LOW_RD;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    r_out_v     <= 1'b1;
                    r_out_stat  <= r_stat;
                    r_out_grant <= r_grant;
                    r_out_brk   <= BRK_W'(r_break);
                    r_state     <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`include "page_run_allocator_assert.svh"

    `PRA_IMPLY(a_no_take_while_full, o_s_axis_tready, !o_m_axis_tvalid, "request taken with result pending")
    `PRA_CHECK(a_break_in_region, r_break < CW'(REGION_PAGES), "break beyond region")
    `PRA_IMPLY(a_fail_no_grant, o_m_axis_tvalid && (o_m_axis_tuser == ST_NOT_FOUND || o_m_axis_tuser == ST_NO_SPACE || o_m_axis_tuser == ST_ZERO), o_m_axis_tdata[19:0] == '0, "grant on failed request")
    `PRA_IMPLY(a_done_loads_out, r_state == S_DONE, ##1 o_m_axis_tvalid, "result not presented")

endmodule

`default_nettype wire

// ===== bench/page_run_allocator_test.sv =====
// ----------------------------------------------------------------------------
// page_run_allocator_test
// Self-checking bench for the page run allocator. A directed table covers
// zero and oversized requests, exact and largest fit, frees that miss and
// a dropping break. A full table, region wrap and random traffic under several
// base and limit settings follow. Result beats are checked against a predictor
// of the allocation table and the break, or against the directed table's fixed values.
// ----------------------------------------------------------------------------
module page_run_allocator_test;
    import pra_pkg::*;

    localparam int NPAGES   = 1024;
    localparam int NENTRIES = 64;

    typedef struct {
        logic              op;
        int                req;
        logic [PAGE_W-1:0] page;
        bit                typed;
        logic [STAT_W-1:0] st;
        logic [PAGE_W-1:0] grant;
        logic [BRK_W-1:0]  brk;
    } t_req_row;

    typedef struct {
        logic [STAT_W-1:0] st;
        logic [PAGE_W-1:0] grant;
        logic [BRK_W-1:0]  brk;
    } t_grant;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [STAT_W-1:0] m_tuser;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    page_run_allocator dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_tvalid), .o_s_axis_tready(s_tready),
        .i_s_axis_tdata(s_tdata), .i_s_axis_tuser(s_tuser),
        .o_m_axis_tvalid(m_tvalid), .i_m_axis_tready(m_tready),
        .o_m_axis_tdata(m_tdata), .o_m_axis_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predictor state: the allocation table, the break and the registers.
    int  ent_start [NENTRIES];
    int  ent_len   [NENTRIES];
    bit  ent_valid [NENTRIES];
    int  brk_pages;
    int  base_reg;
    int  usable_reg;

    t_grant grants_due[$];
    int     errors;
    int     beats_seen;
    int     unrec_seen;
    bit     calm;
    bit     hold_req;

    function automatic int limit_now();
        return (usable_reg > NPAGES) ? NPAGES : usable_reg;
    endfunction

    function automatic bit page_taken(int p);
        for (int i = 0; i < NENTRIES; i++)
            if (ent_valid[i] && p >= ent_start[i] && p < ent_start[i] + ent_len[i])
                return 1'b1;
        return 1'b0;
    endfunction

    function automatic t_grant alloc_pages(int req);
        t_grant g;
        bit have_exact, have_big, busy;
        int exact_at, big_at, big_len, run_at, run_len, at;
        have_exact = 0; have_big = 0;
        exact_at = 0; big_at = 0; big_len = 0; run_at = 0; run_len = 0; at = 0;
        g.grant = '0;
        if (req == 0) begin
            g.st = ST_ZERO;
            g.brk = brk_pages[BRK_W-1:0];
            return g;
        end
        for (int p = 0; p <= brk_pages; p++) begin
            busy = (p == brk_pages) || page_taken(p);
            if (!busy) begin
                if (run_len == 0) run_at = p;
                run_len++;
            end else begin
                if (run_len >= req) begin
                    if (run_len == req && !have_exact) begin
                        have_exact = 1; exact_at = run_at;
                    end
                    if (run_len > big_len) begin
                        have_big = 1; big_len = run_len; big_at = run_at;
                    end
                end
                run_len = 0;
            end
        end
        if (have_exact) at = exact_at;
        else if (have_big) at = big_at;
        else if (brk_pages + req < limit_now()) begin
            at = brk_pages;
            brk_pages += req;
        end else begin
            g.st = ST_NO_SPACE;
            g.brk = brk_pages[BRK_W-1:0];
            return g;
        end
        g.st = ST_UNRECORDED;
        for (int i = 0; i < NENTRIES; i++)
            if (!ent_valid[i]) begin
                ent_valid[i] = 1; ent_start[i] = at; ent_len[i] = req;
                g.st = ST_OK;
                break;
            end
        g.grant = PAGE_W'(base_reg + at);
        g.brk = brk_pages[BRK_W-1:0];
        return g;
    endfunction

    function automatic t_grant free_pages(logic [PAGE_W-1:0] page);
        t_grant g;
        logic [PAGE_W-1:0] rel;
        int idx;
        rel = page - PAGE_W'(base_reg);
        idx = -1;
        g.grant = '0;
        g.st = ST_NOT_FOUND;
        if (rel < limit_now()) begin
            // The highest matching index wins when starts repeat.
            for (int i = 0; i < NENTRIES; i++)
                if (ent_valid[i] && ent_start[i] == rel) idx = i;
            if (idx >= 0) begin
                ent_valid[idx] = 0;
                while (brk_pages > 0 && !page_taken(brk_pages - 1)) brk_pages--;
                g.st = ST_OK;
            end
        end
        g.brk = brk_pages[BRK_W-1:0];
        return g;
    endfunction

    // Result side: random stalls, plus one long hold-off on request.
    initial begin
        int gap, hold;
        gap = 0; hold = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req && hold == 0) begin
                hold = 400;
                hold_req = 0;
            end
            if (hold > 0) begin
                hold--;
                m_tready <= 1'b0;
            end else if (gap > 0) begin
                gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (!calm) begin
                    if ($urandom_range(0, 39) == 0) gap = $urandom_range(20, 90);
                    else if ($urandom_range(0, 5) == 0) gap = $urandom_range(1, 3);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_grant e;
        if (i_rst_n && m_tvalid && m_tready) begin
            beats_seen++;
            if (grants_due.size() == 0) begin
                $error("result beat with nothing expected: status %0d", m_tuser);
                errors++;
            end else begin
                e = grants_due.pop_front();
                if (e.st == ST_UNRECORDED) unrec_seen++;
                if (m_tuser !== e.st) begin
                    $error("status: expected %0d, got %0d", e.st, m_tuser);
                    errors++;
                end
                if (m_tdata[19:0] !== e.grant) begin
                    $error("grant_page: expected %0h, got %0h", e.grant, m_tdata[19:0]);
                    errors++;
                end
                if (m_tdata[30:20] !== e.brk) begin
                    $error("break_now: expected %0d, got %0d", e.brk, m_tdata[30:20]);
                    errors++;
                end
            end
        end
    end

    task automatic send_req(t_req_row r);
        int gap;
        t_grant g;
        gap = 0;
        if (!calm) begin
            if ($urandom_range(0, 29) == 0) gap = $urandom_range(20, 80);
            else if ($urandom_range(0, 2) == 0) gap = $urandom_range(1, 3);
        end
        if (gap > 0) begin
            @(negedge i_clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_tvalid <= 1'b1;
        s_tuser  <= r.op;
        s_tdata  <= {1'b0, r.page, 11'(r.req)};
        do @(posedge i_clk); while (!s_tready);
        g = (r.op == OP_ALLOC) ? alloc_pages(r.req) : free_pages(r.page);
        if (r.typed) begin
            g.st = r.st; g.grant = r.grant; g.brk = r.brk;
        end
        grants_due.push_back(g);
    endtask

    task automatic drain();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        wait (grants_due.size() == 0);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic apb_write(logic [2:0] addr, int value);
        @(negedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= addr; pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (addr == 3'h0) base_reg = value & 32'hFFFFF;
        else usable_reg = value & 32'h7FF;
    endtask

    function automatic t_req_row plain(logic op, int req, logic [PAGE_W-1:0] page);
        t_req_row r;
        r.op = op; r.req = req; r.page = page; r.typed = 0;
        r.st = '0; r.grant = '0; r.brk = '0;
        return r;
    endfunction

    function automatic t_req_row known(logic op, int req, logic [PAGE_W-1:0] page,
                                       logic [STAT_W-1:0] st, logic [PAGE_W-1:0] gr,
                                       int bk);
        t_req_row r;
        r = plain(op, req, page);
        r.typed = 1; r.st = st; r.grant = gr; r.brk = BRK_W'(bk);
        return r;
    endfunction

    // Mostly small allocations and frees of live starts, with some noise.
    function automatic t_req_row random_req(int big_pct);
        t_req_row r;
        int idx;
        if ($urandom_range(0, 99) < 55) begin
            if ($urandom_range(0, 99) < big_pct) r = plain(OP_ALLOC, $urandom_range(0, 1024), '0);
            else r = plain(OP_ALLOC, $urandom_range(0, 12), 20'($urandom));
        end else begin
            r = plain(OP_FREE, 0, 20'($urandom));
            if ($urandom_range(0, 9) < 8) begin
                for (int t = 0; t < 16; t++) begin
                    idx = $urandom_range(0, NENTRIES - 1);
                    if (ent_valid[idx]) begin
                        r.page = PAGE_W'(base_reg + ent_start[idx]);
                        break;
                    end
                end
            end
            r.req = $urandom_range(0, 2047) & 11'h7FF;
        end
        return r;
    endfunction

    task automatic random_phase(int count, int big_pct);
        for (int n = 0; n < count; n++) send_req(random_req(big_pct));
    endtask

    t_req_row dir_tab[$];

    initial begin
        errors = 0; beats_seen = 0; unrec_seen = 0; calm = 0; hold_req = 0;
        for (int i = 0; i < NENTRIES; i++) begin
            ent_start[i] = 0; ent_len[i] = 0; ent_valid[i] = 0;
        end
        brk_pages = 0; base_reg = 0; usable_reg = 1024;

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        dir_tab.push_back(known(OP_ALLOC, 0, 20'hFFFFF, ST_ZERO, 20'h0, 0));
        dir_tab.push_back(known(OP_ALLOC, 1024, '0, ST_NO_SPACE, 20'h0, 0));
        dir_tab.push_back(known(OP_FREE, 0, 20'h0, ST_NOT_FOUND, 20'h0, 0));
        dir_tab.push_back(known(OP_ALLOC, 1, '0, ST_OK, 20'h0, 1));
        dir_tab.push_back(known(OP_ALLOC, 3, '0, ST_OK, 20'h1, 4));
        dir_tab.push_back(known(OP_ALLOC, 2, '0, ST_OK, 20'h4, 6));
        dir_tab.push_back(known(OP_FREE, 2047, 20'hFFFFF, ST_NOT_FOUND, 20'h0, 6));
        dir_tab.push_back(plain(OP_FREE, 0, 20'h1));
        dir_tab.push_back(plain(OP_ALLOC, 3, '0));      // exact fit in the hole
        dir_tab.push_back(plain(OP_FREE, 0, 20'h1));
        dir_tab.push_back(plain(OP_ALLOC, 1, '0));      // largest fit in the hole
        dir_tab.push_back(plain(OP_FREE, 0, 20'h4));    // break drops back
        dir_tab.push_back(plain(OP_FREE, 0, 20'h1));
        dir_tab.push_back(plain(OP_ALLOC, 1023, '0));   // would end at the limit, so refused
        dir_tab.push_back(plain(OP_ALLOC, 1022, '0));
        dir_tab.push_back(plain(OP_FREE, 0, 20'h1));
        dir_tab.push_back(plain(OP_FREE, 0, 20'h0));
        foreach (dir_tab[k]) send_req(dir_tab[k]);

        // Fill the table past its depth so grants come back unrecorded.
        drain();
        apb_write(3'h0, 32'h00010);
        apb_write(3'h4, 1024);
        calm = 1;
        for (int n = 0; n < 70; n++) send_req(plain(OP_ALLOC, 1, '0));
        calm = 0;
        for (int n = 0; n < 30; n++) send_req(plain(OP_FREE, 0, 20'(32'h10 + $urandom_range(0, 80))));
        hold_req = 1;
        random_phase(20, 2);

        // Region that wraps the page number, and a small limit.
        drain();
        apb_write(3'h0, 32'hFFFF0);
        apb_write(3'h4, 120);
        random_phase(60, 5);

        // A limit of one page forbids every extension.
        drain();
        apb_write(3'h4, 1);
        random_phase(12, 20);

        drain();
        apb_write(3'h0, 32'h0);
        apb_write(3'h4, 2047);
        random_phase(40, 8);

        drain();
        apb_write(3'h0, 32'h5A5A5);
        apb_write(3'h4, 300);
        random_phase(40, 10);

        drain();
        repeat (50) @(negedge i_clk);
        $display("Covered %0d result beats, %0d of them unrecorded grants, over six",
                 beats_seen, unrec_seen);
        $display("base and limit settings with random stalls on both sides.");
        if (errors == 0)
            $display("page_run_allocator: match");
        else
            $display("page_run_allocator: mismatch");
        $finish;
    end

    initial begin
        #40_000_000;
        $display("page_run_allocator: mismatch");
        $finish;
    end
endmodule
